### rtl/falu_pkg.sv
// shared types and constants of the q24.8 fixed-point alu
// used by falu_cell, falu_finish and the top level; no dependencies
package falu_pkg;

    // operation codes
    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_MIN      = 4'd4,
        OP_MAX      = 4'd5,
        OP_INC      = 4'd6,
        OP_DEC      = 4'd7,
        OP_TO_INT   = 4'd8,
        OP_FROM_INT = 4'd9,
        OP_CMP      = 4'd10
    } op_t;

    // fault codes
    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_DIV0 = 2'd1;
    localparam logic [1:0] FAULT_OVF  = 2'd2;

    // dividend field holds |a| << FRAC_BITS left aligned, room for up to 16 fraction bits
    localparam int NUM_W = 48;

    // one request as it moves down the chain
    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [63:0] prod;
        logic [31:0]        dvs;
        logic [NUM_W-1:0]   num;
        logic [31:0]        rem;
        logic [NUM_W-1:0]   quot;
    } item_t;

endpackage

### rtl/falu_cell.sv
// one divider cell: a restoring step on one dividend bit, payload carried along
// depends on falu_pkg
module falu_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  falu_pkg::item_t in_item,
    output logic           out_valid,
    output falu_pkg::item_t out_item
);
    import falu_pkg::*;

    logic            valid_reg;
    item_t           item_reg;
    item_t           item_next;
    logic [32:0]     rem_ext;
    logic [32:0]     rem_diff;
    logic            ge;

    // shift in the next dividend bit and try a subtract
    always_comb begin
        rem_ext   = {in_item.rem, in_item.num[NUM_W-1]};
        rem_diff  = rem_ext - {1'b0, in_item.dvs};
        ge        = (rem_ext >= {1'b0, in_item.dvs});
        item_next = in_item;
        item_next.rem  = ge ? rem_diff[31:0] : rem_ext[31:0];
        item_next.num  = {in_item.num[NUM_W-2:0], 1'b0};
        item_next.quot = {in_item.quot[NUM_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
endmodule

### rtl/falu_finish.sv
// result selection: rounding, saturation, flags and fault of a finished request
// depends on falu_pkg
module falu_finish #(
    parameter int FRAC_BITS = 8
) (
    input  falu_pkg::item_t item,
    output logic [31:0]     result,
    output logic            less,
    output logic            equal,
    output logic            greater,
    output logic [1:0]      fault
);
    import falu_pkg::*;

    localparam logic signed [63:0] HALF =
        (FRAC_BITS == 0) ? 64'sd0 : (64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [32:0] TRUNC_ADJ = (33'sd1 <<< FRAC_BITS) - 33'sd1;
    localparam logic signed [63:0] MAX32 = 64'sd2147483647;
    localparam logic signed [63:0] MIN32 = -64'sd2147483648;

    // saturate to 32 bits, overflow flag on top
    function automatic logic [32:0] sat64(input logic signed [63:0] v);
        logic [32:0] r;
        if (v > MAX32) begin
            r = {1'b1, 32'h7fff_ffff};
        end else if (v < MIN32) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    logic signed [63:0] a64;
    logic signed [63:0] b64;
    logic signed [63:0] mul_rnd;
    logic signed [63:0] shl_a;
    logic signed [32:0] trunc_sum;
    logic [NUM_W:0]     q_rnd;
    logic               div_neg;
    logic [32:0]        s;

    always_comb begin
        a64 = {{32{item.a[31]}}, item.a};
        b64 = {{32{item.b[31]}}, item.b};
        // half away from zero on the raw product
        if (FRAC_BITS == 0) begin
            mul_rnd = item.prod;
        end else if (item.prod < 0) begin
            mul_rnd = (item.prod + HALF - 64'sd1) >>> FRAC_BITS;
        end else begin
            mul_rnd = (item.prod + HALF) >>> FRAC_BITS;
        end
        shl_a     = a64 <<< FRAC_BITS;
        trunc_sum = ($signed({item.a[31], item.a}) +
                     (item.a[31] ? TRUNC_ADJ : 33'sd0)) >>> FRAC_BITS;
        // quotient rounding from the final remainder
        q_rnd   = {1'b0, item.quot} +
                  {{NUM_W{1'b0}}, ({item.rem, 1'b0} >= {1'b0, item.dvs})};
        div_neg = item.a[31] ^ item.b[31];

        less    = (item.a < item.b);
        equal   = (item.a == item.b);
        greater = (item.a > item.b);
        result  = 32'd0;
        fault   = FAULT_NONE;
        s       = 33'd0;

        case (item.op)
            OP_ADD:      s = sat64(a64 + b64);
            OP_SUB:      s = sat64(a64 - b64);
            OP_MUL:      s = sat64(mul_rnd);
            OP_INC:      s = sat64(a64 + 64'sd1);
            OP_DEC:      s = sat64(a64 - 64'sd1);
            OP_FROM_INT: s = sat64(shl_a);
            OP_MIN:      s = {1'b0, less ? item.a : item.b};
            OP_MAX:      s = {1'b0, greater ? item.a : item.b};
            OP_TO_INT:   s = {1'b0, trunc_sum[31:0]};
            OP_DIV: begin
                if (item.dvs == 32'd0) begin
                    s = 33'd0;
                end else if (!div_neg) begin
                    if (q_rnd > (NUM_W + 1)'(32'h7fff_ffff)) begin
                        s = {1'b1, 32'h7fff_ffff};
                    end else begin
                        s = {1'b0, q_rnd[31:0]};
                    end
                end else begin
                    if (q_rnd > (NUM_W + 1)'(32'h8000_0000)) begin
                        s = {1'b1, 32'h8000_0000};
                    end else begin
                        s = {1'b0, 32'd0 - q_rnd[31:0]};
                    end
                end
            end
            default:     s = 33'd0;
        endcase

        result = s[31:0];
        if (item.op == OP_DIV && item.dvs == 32'd0) begin
            fault = FAULT_DIV0;
        end else if (s[32]) begin
            fault = FAULT_OVF;
        end
    end
endmodule

### rtl/fixed_point_alu_q24_8.sv
// top level of the q24.8 fixed-point alu: entry stage, divider cell chain, output register
// depends on falu_pkg, falu_cell, falu_finish
//
//  channel | dir | tdata fields (low bit up)                      | tuser
//  s_      | in  | op[3:0] first_operand[35:4] second_op[67:36]   | none
//  m_      | out | result[31:0] less[32] equal[33] greater[34]    | none
//          |     | fault[36:35]                                   |
//
// one request per cycle while the chain is not halted; 34 + FRAC_BITS register stages,
// a count that the divider chain sets, one restoring cell per quotient bit of
// (|a| << FRAC_BITS) / |b|
// the whole chain advances together; it halts only while a result waits in the
// output register and m_tready is low, and s_tready follows that same enable
// reset clears every valid bit; payload registers are not reset
module fixed_point_alu_q24_8 #(
    parameter int FRAC_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // op, first_operand, second_operand, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // result, less, equal, greater, fault, zero fill
);
    import falu_pkg::*;

    localparam int NCELL = 32 + FRAC_BITS;

    logic               en;
    logic               v_chain [0:NCELL];
    item_t              i_chain [0:NCELL];
    item_t              entry_next;
    logic signed [31:0] in_a;
    logic signed [31:0] in_b;
    logic               valid0_reg;
    item_t              item0_reg;
    logic               m_valid_reg;
    logic [39:0]        m_data_reg;
    logic [39:0]        m_data_next;
    logic [31:0]        fin_result;
    logic               fin_less;
    logic               fin_equal;
    logic               fin_greater;
    logic [1:0]         fin_fault;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // entry: unpack, multiply, magnitudes for the divider
    always_comb begin
        in_a = $signed(s_tdata[35:4]);
        in_b = $signed(s_tdata[67:36]);
        entry_next.op   = s_tdata[3:0];
        entry_next.a    = in_a;
        entry_next.b    = in_b;
        entry_next.prod = in_a * in_b;
        entry_next.dvs  = in_b[31] ? (32'd0 - in_b) : in_b;
        entry_next.num  = {(in_a[31] ? (32'd0 - in_a) : in_a), 16'd0};
        entry_next.rem  = 32'd0;
        entry_next.quot = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid0_reg <= 1'b0;
        end else if (en) begin
            valid0_reg <= s_tvalid;
        end
        if (en) begin
            item0_reg <= entry_next;
        end
    end

    assign v_chain[0] = valid0_reg;
    assign i_chain[0] = item0_reg;

    // divider chain, one cell per quotient bit
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        falu_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (v_chain[g]),
            .in_item   (i_chain[g]),
            .out_valid (v_chain[g+1]),
            .out_item  (i_chain[g+1])
        );
    end

    falu_finish #(
        .FRAC_BITS (FRAC_BITS)
    ) u_finish (
        .item    (i_chain[NCELL]),
        .result  (fin_result),
        .less    (fin_less),
        .equal   (fin_equal),
        .greater (fin_greater),
        .fault   (fin_fault)
    );

    assign m_data_next = {3'd0, fin_fault, fin_greater, fin_equal, fin_less, fin_result};

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v_chain[NCELL];
        end
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
endmodule

### rtl/falu_checker.sv
// port-level checks of the q24.8 fixed-point alu, bound to the top level
// depends on fixed_point_alu_q24_8
module falu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);
    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // exactly one relation flag
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot(m_tdata[34:32]))
        else $error("relation flags not one-hot");

    // divide by zero gives a zero result, unused fault code never appears
    a_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[36:35] != 2'd3) &&
                     (m_tdata[36:35] != 2'd1 || m_tdata[31:0] == 32'd0))
        else $error("bad fault code or result");

    // input side is open whenever the output is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");
endmodule

bind fixed_point_alu_q24_8 falu_checker u_falu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
